>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold whenever the condition is true
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// property must hold in the cycle after the condition
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

>>> rtl/core/sltk_pkg.sv
// shared types and constants for the shadow light selector
package sltk_pkg;
    localparam int MaxShadowed = 8;
    localparam int MaxLights   = 1024;
    localparam int IdxW        = $clog2(MaxLights);
    localparam int SlotW       = $clog2(MaxShadowed);
    localparam int CntW        = $clog2(MaxShadowed + 1);
    localparam int ScoreW      = 48;
    localparam int SqW         = 50;
    localparam int DistW       = 25;
    localparam int RatioW      = 24;
    localparam int QuotW       = 40;
    localparam logic [24:0] MinPrio  = 25'd64;
    localparam logic [1:0]  RegCamX = 2'd0;
    localparam logic [1:0]  RegCamY = 2'd1;
    localparam logic [1:0]  RegCamZ = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture item, start squares
        logic sq_step;    // accumulate one square
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic mul_step;   // square the ratio
        logic ins_init;
        logic ins_step;   // compare with one kept entry
        logic ins_write;
        logic cnt_adv;
        logic frame_clr;
        logic emit_load;
        logic emit_adv;
    } sltk_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_view;
        logic final_light;
        logic ins_done;
        logic emit_last;
    } sltk_stat_t;
endpackage

>>> rtl/core/sltk_datapath.sv
// arithmetic units, kept list and result register
module sltk_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 in_view,
    input  logic signed [23:0]   center_x,
    input  logic signed [23:0]   center_y,
    input  logic signed [23:0]   center_z,
    input  logic [23:0]          bounds_radius,
    input  logic                 final_light,
    input  sltk_pkg::sltk_cmd_t  cmd,
    output sltk_pkg::sltk_stat_t stat,
    output logic [2:0]           shadow_slot,
    output logic [9:0]           chosen_index,
    output logic                 selected,
    output logic                 run_end
);
    import sltk_pkg::*;

    logic signed [23:0] cam_reg [3];
    logic signed [23:0] ctr_reg [3];
    logic [23:0]        rad_reg;
    logic               view_reg, fin_reg;
    logic [1:0]         axis_reg;
    logic [SqW-1:0]     sq_reg, rem_reg, root_reg;
    logic [5:0]         iter_reg;
    logic [QuotW-1:0]   quo_reg;
    logic [DistW:0]     drem_reg;
    logic [DistW-1:0]   prio_reg;
    logic [ScoreW-1:0]  score_reg;
    logic [IdxW-1:0]    lcnt_reg;
    logic [ScoreW-1:0]  kscore_reg [MaxShadowed];
    logic [IdxW-1:0]    kidx_reg [MaxShadowed];
    logic [CntW-1:0]    kcnt_reg;
    logic [CntW-1:0]    pos_reg;
    logic               ins_done;
    logic [CntW-1:0]    eptr_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++) cam_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegCamX: cam_reg[0] <= cfg_data;
                RegCamY: cam_reg[1] <= cfg_data;
                RegCamZ: cam_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // one square per step
    logic signed [24:0] diff;
    logic [SqW-1:0]     sqr;
    assign diff = 25'(ctr_reg[axis_reg]) - 25'(cam_reg[axis_reg]);
    assign sqr  = SqW'(diff * diff);

    // one root bit per step
    logic [SqW-1:0] trial;
    logic [SqW-1:0] rbit;
    assign rbit  = SqW'(1) << {iter_reg, 1'b0};
    assign trial = root_reg + rbit;

    // prio from root
    logic signed [DistW+1:0] pdiff;
    assign pdiff = $signed({2'b0, root_reg[DistW-1:0]}) - $signed({3'b0, rad_reg});

    // restoring divider, one quotient bit per step
    logic [DistW:0] dshift;
    logic           dbit;
    assign dshift = {drem_reg[DistW-1:0], quo_reg[QuotW-1]};
    assign dbit   = dshift >= {1'b0, prio_reg};

    logic [RatioW-1:0] ratio;
    assign ratio = (|quo_reg[QuotW-1:RatioW]) ? '1 : quo_reg[RatioW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ctr_reg[0] <= center_x;
            ctr_reg[1] <= center_y;
            ctr_reg[2] <= center_z;
            rad_reg    <= bounds_radius;
            view_reg   <= in_view;
            fin_reg    <= final_light;
            axis_reg   <= '0;
            sq_reg     <= '0;
        end
        if (cmd.sq_step)
        begin
            sq_reg   <= sq_reg + sqr;
            axis_reg <= axis_reg + 2'd1;
        end
        if (cmd.sqrt_init)
        begin
            rem_reg  <= sq_reg;
            root_reg <= '0;
            iter_reg <= 6'd24;
        end
        if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + rbit;
            end
            else
                root_reg <= root_reg >> 1;
            iter_reg <= iter_reg - 6'd1;
        end
        if (cmd.div_init)
        begin
            prio_reg <= (pdiff < $signed({2'b0, MinPrio})) ? MinPrio
                                                          : pdiff[DistW-1:0];
            quo_reg  <= {rad_reg, 16'b0};
            drem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= dbit ? dshift - {1'b0, prio_reg} : dshift;
            quo_reg  <= {quo_reg[QuotW-2:0], dbit};
        end
        if (cmd.mul_step)
            score_reg <= ScoreW'(ratio) * ScoreW'(ratio);
    end

    // kept list insertion: scan for first entry below the score
    assign ins_done = (pos_reg >= kcnt_reg) || (kscore_reg[SlotW'(pos_reg)] < score_reg)
                      || (pos_reg == CntW'(MaxShadowed));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            kcnt_reg <= '0;
            pos_reg  <= '0;
            eptr_reg <= '0;
            for (int i = 0; i < MaxShadowed; i++)
            begin
                kscore_reg[i] <= '0;
                kidx_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.ins_init) pos_reg <= '0;
            if (cmd.ins_step && !ins_done) pos_reg <= pos_reg + CntW'(1);
            if (cmd.ins_write && pos_reg < CntW'(MaxShadowed))
            begin
                for (int k = MaxShadowed - 1; k > 0; k--)
                begin
                    if (CntW'(k) > pos_reg)
                    begin
                        kscore_reg[k] <= kscore_reg[k-1];
                        kidx_reg[k]   <= kidx_reg[k-1];
                    end
                end
                kscore_reg[SlotW'(pos_reg)] <= score_reg;
                kidx_reg[SlotW'(pos_reg)]   <= lcnt_reg;
                if (kcnt_reg < CntW'(MaxShadowed)) kcnt_reg <= kcnt_reg + CntW'(1);
            end
            if (cmd.cnt_adv) lcnt_reg <= lcnt_reg + IdxW'(1);
            if (cmd.emit_load) eptr_reg <= '0;
            if (cmd.emit_adv) eptr_reg <= eptr_reg + CntW'(1);
            if (cmd.frame_clr)
            begin
                lcnt_reg <= '0;
                kcnt_reg <= '0;
            end
        end
    end

    // result fields from the emit pointer
    logic [CntW-1:0] enext;
    assign enext        = eptr_reg + CntW'(1);
    assign selected     = kcnt_reg != '0;
    assign shadow_slot  = 3'(eptr_reg);
    assign chosen_index = selected ? 10'(kidx_reg[SlotW'(eptr_reg)]) : '0;
    assign run_end      = !selected || (enext == kcnt_reg);

    assign stat.in_view     = view_reg;
    assign stat.final_light = fin_reg;
    assign stat.ins_done    = ins_done;
    assign stat.emit_last   = run_end;
endmodule

>>> rtl/core/sltk_ctrl.sv
// sequencing state machine for one light
module sltk_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  sltk_pkg::sltk_stat_t stat,
    output sltk_pkg::sltk_cmd_t  cmd
);
    import sltk_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_SQRT = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_INS  = 9'b000100000,
        S_NEXT = 9'b001000000,
        S_EMIT = 9'b010000000,
        S_PRE  = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_EMIT;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (!stat.in_view)
                    state_next = S_NEXT;
                else
                begin
                    cmd.sq_step = 1'b1;
                    cnt_next    = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd2)
                        state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd24)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 6'd0)
                    cmd.div_init = 1'b1;
                else
                    cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(QuotW))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.ins_init = 1'b1;
                state_next   = S_INS;
            end
            S_INS:
            begin
                cmd.ins_step = 1'b1;
                if (stat.ins_done)
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.cnt_adv = 1'b1;
                if (stat.final_light)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (stat.emit_last)
                    begin
                        cmd.frame_clr = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                        cmd.emit_adv = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/shadow_light_top_k_select.sv
// Shadow light top-k selector. One light at a time: a visible light passes
// through the accepting idle state, 3 squares, a setup step, 25 root steps,
// the divider setup and steps, one multiply, 1 to 9 list compares and a
// count update; the square root and divider are bit-serial. A light not in
// view goes from the squares state straight to the count update. On the
// final light the kept indices come out one per cycle while out_stall is
// low, in rank order, and no new light is taken meanwhile.
`include "assert_macros.svh"
module shadow_light_top_k_select (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               in_view,
    input  logic signed [23:0] center_x,
    input  logic signed [23:0] center_y,
    input  logic signed [23:0] center_z,
    input  logic [23:0]        bounds_radius,
    input  logic               final_light,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         shadow_slot,
    output logic [9:0]         chosen_index,
    output logic               selected,
    output logic               run_end
);
    import sltk_pkg::*;

    sltk_cmd_t  cmd;
    sltk_stat_t stat;

    assign cfg_ready = 1'b1;

    sltk_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
    );

    sltk_datapath u_dp (
        .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .in_view, .center_x,
        .center_y, .center_z, .bounds_radius, .final_light, .cmd, .stat,
        .shadow_slot, .chosen_index, .selected, .run_end
    );

    // checks
    `ASSERT_IMPLY(a_no_take_busy, clk, rst_n, out_valid, in_stall)
    `ASSERT_IMPLY(a_empty_ends, clk, rst_n, out_valid && !selected, run_end)
    `ASSERT_NEXT(a_end_idle, clk, rst_n, out_valid && !out_stall && run_end, !out_valid)
endmodule

>>> verif/tb_shadow_light_top_k_select.sv
// testbench for the shadow light top-k selector: directed and random frames
`timescale 1ns / 1ps
module tb_shadow_light_top_k_select;
    import sltk_pkg::*;

    typedef struct packed {
        logic [2:0] slot;
        logic [9:0] idx;
        logic       sel;
        logic       last;
    } pick_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               in_view;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [23:0]        bounds_radius;
    logic               final_light;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         shadow_slot;
    logic [9:0]         chosen_index;
    logic               selected;
    logic               run_end;

    // predictor state
    logic signed [23:0] cam_x, cam_y, cam_z;
    logic [9:0]         light_num;
    int                 num_kept;
    logic [47:0]        rank_score [MaxShadowed];
    logic [9:0]         rank_idx [MaxShadowed];
    pick_t              picks_due [$];

    int  errors;
    int  hold_cycles;
    bit  burst_mode;

    shadow_light_top_k_select dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .in_view(in_view), .center_x(center_x), .center_y(center_y),
        .center_z(center_z), .bounds_radius(bounds_radius),
        .final_light(final_light),
        .out_valid(out_valid), .out_stall(out_stall),
        .shadow_slot(shadow_slot), .chosen_index(chosen_index),
        .selected(selected), .run_end(run_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // bit-serial integer root
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // score of one light against the current camera
    function automatic logic [47:0] light_weight(input logic signed [23:0] x,
        input logic signed [23:0] y, input logic signed [23:0] z,
        input logic [23:0] r);
        longint dx, dy, dz, span, prio;
        logic [63:0] sq, ratio;
        dx = longint'(x) - longint'(cam_x);
        dy = longint'(y) - longint'(cam_y);
        dz = longint'(z) - longint'(cam_z);
        sq = dx * dx + dy * dy + dz * dz;
        span = longint'(int_root(sq));
        prio = span - longint'({40'd0, r});
        if (prio < 64)
            prio = 64;
        ratio = ({40'd0, r} << 16) / prio;
        if (ratio > 64'hFFFFFF)
            ratio = 64'hFFFFFF;
        return 48'(ratio * ratio);
    endfunction

    // update the ranking and queue the run on the final light
    task automatic predict_light(input logic v, input logic signed [23:0] x,
        input logic signed [23:0] y, input logic signed [23:0] z,
        input logic [23:0] r, input logic fin);
        logic [47:0] s;
        int pos, last;
        pick_t p;
        if (v)
        begin
            s = light_weight(x, y, z, r);
            pos = 0;
            while (pos < num_kept && rank_score[pos] >= s)
                pos++;
            if (pos < MaxShadowed)
            begin
                last = (num_kept < MaxShadowed) ? num_kept : MaxShadowed - 1;
                for (int k = last; k > pos; k--)
                begin
                    rank_score[k] = rank_score[k - 1];
                    rank_idx[k] = rank_idx[k - 1];
                end
                rank_score[pos] = s;
                rank_idx[pos] = light_num;
                if (num_kept < MaxShadowed)
                    num_kept++;
            end
        end
        light_num = light_num + 10'd1;
        if (fin)
        begin
            if (num_kept == 0)
            begin
                p = '{slot: 3'd0, idx: 10'd0, sel: 1'b0, last: 1'b1};
                picks_due = {picks_due, p};
            end
            else
                for (int k = 0; k < num_kept; k++)
                begin
                    p = '{slot: 3'(k), idx: rank_idx[k], sel: 1'b1,
                          last: (k + 1 == num_kept)};
                    picks_due = {picks_due, p};
                end
            light_num = 0;
            num_kept = 0;
        end
    endtask

    // send one light item
    task automatic send_light(input logic v, input logic signed [23:0] x,
        input logic signed [23:0] y, input logic signed [23:0] z,
        input logic [23:0] r, input logic fin);
        in_valid <= 1'b1;
        in_view <= v;
        center_x <= x;
        center_y <= y;
        center_z <= z;
        bounds_radius <= r;
        final_light <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_light(v, x, y, z, r, fin);
        // bursts with random gaps
        if (burst_mode && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // wait until every queued result has come, then let the block settle
    task automatic drain;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (picks_due.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (120) @(posedge clk);
    endtask

    // write one camera register while idle
    task automatic write_reg(input logic [1:0] ri, input logic signed [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (ri)
            RegCamX: cam_x = val;
            RegCamY: cam_y = val;
            default: cam_z = val;
        endcase
    endtask

    task automatic set_camera(input logic signed [23:0] x,
        input logic signed [23:0] y, input logic signed [23:0] z);
        drain();
        write_reg(RegCamX, x);
        write_reg(RegCamY, y);
        write_reg(RegCamZ, z);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 8000)) - 4000);
            2: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [23:0] rand_radius();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 3000));
            2: return ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'd0;
            default: return 24'($urandom_range(0, 60000));
        endcase
    endfunction

    // directed: extremes and special cases
    task automatic test_directed;
        // empty frame, nothing in view
        send_light(1'b0, 24'h7FFFFF, 24'h800000, 24'd0, 24'hFFFFFF, 1'b1);
        // final light in view, alone
        send_light(1'b1, 24'd256, 24'd0, 24'd0, 24'd128, 1'b1);
        // radius covering the camera, saturated ratio, and zero radius
        send_light(1'b1, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 1'b0);
        send_light(1'b1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 1'b0);
        send_light(1'b1, 24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF, 1'b0);
        // equal scores, the earlier one ranks first
        send_light(1'b1, 24'd1000, 24'd0, 24'd0, 24'd100, 1'b0);
        send_light(1'b1, 24'd0, 24'd1000, 24'd0, 24'd100, 1'b0);
        send_light(1'b0, 24'd5, 24'd5, 24'd5, 24'd5, 1'b0);
        // overfill the list
        for (int k = 0; k < 10; k++)
            send_light(1'b1, 24'(k * 300 + 500), 24'd0, 24'd0, 24'(k * 40), 1'b0);
        send_light(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    endtask

    // random frames, mostly short, with camera changes
    task automatic test_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            int len;
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++)
            begin
                send_light($urandom_range(0, 4) != 0, rand_coord(), rand_coord(),
                           rand_coord(), rand_radius(), k == len - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                set_camera(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure;
        hold_cycles = 1500;
        for (int k = 0; k < 20; k++)
            send_light(1'b1, rand_coord(), rand_coord(), rand_coord(),
                       rand_radius(), (k % 5) == 4);
        drain();
    endtask

    // receiver stall pattern and hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (burst_mode)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (picks_due.size() == 0)
            begin
                $display("%0t: unexpected result slot %0d index %0d", $realtime,
                         shadow_slot, chosen_index);
                errors++;
            end
            else
            begin
                pick_t p;
                p = picks_due.pop_front();
                if (shadow_slot !== p.slot || chosen_index !== p.idx ||
                    selected !== p.sel || run_end !== p.last)
                begin
                    $display("%0t: expected slot %0d index %0d sel %0d end %0d, got %0d %0d %0d %0d",
                             $realtime, p.slot, p.idx, p.sel, p.last,
                             shadow_slot, chosen_index, selected, run_end);
                    errors++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        errors = 0;
        hold_cycles = 0;
        burst_mode = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = RegCamX;
        cfg_data = 24'd0;
        in_valid = 1'b0;
        in_view = 1'b0;
        center_x = 24'd0;
        center_y = 24'd0;
        center_z = 24'd0;
        bounds_radius = 24'd0;
        final_light = 1'b0;
        out_stall = 1'b0;
        cam_x = 0;
        cam_y = 0;
        cam_z = 0;
        light_num = 0;
        num_kept = 0;
        for (int k = 0; k < MaxShadowed; k++)
        begin
            rank_score[k] = 0;
            rank_idx[k] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_camera(24'h7FFFFF, 24'h800000, 24'd0);
        test_directed();
        burst_mode = 1'b1;
        test_backpressure();
        set_camera(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        test_random(150);
        set_camera(24'd0, 24'd0, 24'd0);
        test_random(160);
        drain();

        if (errors == 0 && picks_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
